FILE: design/hrrm_pkg.sv
`default_nettype none
package hrrm_pkg;
   localparam int REGION_DEPTH = 1024;
   localparam int ENTRY_W = $clog2(REGION_DEPTH);
   localparam int CNT_W = ENTRY_W + 1;
   localparam int IDX_W = 16;
   localparam int WORD_W = 16;
   localparam int COMM_W = 128;
   localparam int PEND_W = COMM_W + 4;

   localparam logic [1:0] OP_READ = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_EXCHANGE = 2'd2;

   localparam int MARK_OUT = 0;
   localparam int MARK_MEM = 1;
   localparam int MARK_DWORD = 2;
   localparam int MARK_QWORD = 3;

   typedef enum logic [1:0] {K_READ, K_WRITE, K_EXCH, K_NOP} kind_type;
   typedef enum logic [1:0] {R_OUT, R_MEM, R_DWORD, R_QWORD} region_type;

   typedef struct packed {
      kind_type kind;
      region_type region;
      logic [ENTRY_W-1:0] entry;
      logic [1:0] part;
      logic [WORD_W-1:0] word;
      logic last;
      logic err;
   } item_type;
endpackage
`default_nettype wire

FILE: design/hrrm_ram.sv
`default_nettype none
module hrrm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/hrrm_front.sv
`default_nettype none
module hrrm_front import hrrm_pkg::*; (
   input wire logic [1:0] req_operation,
   input wire logic [IDX_W-1:0] req_reg_index,
   input wire logic [WORD_W-1:0] req_write_word,
   input wire logic req_last_word,
   output item_type item
);
   localparam logic [IDX_W:0] B1 = (IDX_W+1)'(REGION_DEPTH);
   localparam logic [IDX_W:0] B2 = (IDX_W+1)'(2 * REGION_DEPTH);
   localparam logic [IDX_W:0] B4 = (IDX_W+1)'(4 * REGION_DEPTH);
   localparam logic [IDX_W:0] B8 = (IDX_W+1)'(8 * REGION_DEPTH);

   logic [IDX_W:0] idx;
   logic [IDX_W:0] off;
   logic in_range;

   always_comb begin
      idx = {1'b0, req_reg_index};
      off = idx;
      in_range = (idx < B8);
      item.word = req_write_word;
      item.last = req_last_word;
      item.part = 2'd0;
      item.region = R_OUT;
      item.err = 1'b0;
      if (idx < B1) begin
         off = idx;
         item.region = R_OUT;
      end else if (idx < B2) begin
         off = idx - B1;
         item.region = R_MEM;
      end else if (idx < B4) begin
         off = (idx - B2) >> 1;
         item.part = {1'b0, idx[0] ^ B2[0]};
         item.region = R_DWORD;
      end else begin
         off = (idx - B4) >> 2;
         item.part = 2'(idx - B4);
         item.region = R_QWORD;
      end
      item.entry = off[ENTRY_W-1:0];
      unique case (req_operation)
         OP_READ: begin
            item.kind = in_range ? K_READ : K_NOP;
            item.err = !in_range;
         end
         OP_WRITE: begin
            item.kind = in_range ? K_WRITE : K_NOP;
            item.err = !in_range;
         end
         OP_EXCHANGE: item.kind = K_EXCH;
         default: item.kind = K_NOP;
      endcase
   end
endmodule
`default_nettype wire

FILE: design/hrrm_queue.sv
`default_nettype none
module hrrm_queue import hrrm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire item_type push_item,
   output logic full,
   input wire logic pop,
   output logic head_valid,
   output item_type head
);
   item_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic rd_ptr_ff, wr_ptr_ff;

   assign full = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop of empty queue");
endmodule
`default_nettype wire

FILE: design/hrrm_back.sv
`default_nettype none
module hrrm_back import hrrm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic head_valid,
   input wire item_type head,
   output logic pop,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [WORD_W-1:0] rsp_read_word,
   output logic rsp_status,
   output logic rsp_last_flag
);
   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_DO, S_EXCH, S_EXDONE} state_type;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(REGION_DEPTH);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(REGION_DEPTH - 1);

   state_type state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic wvld_ff;
   logic [ENTRY_W-1:0] waddr_ff;
   logic rsp_valid_ff;
   logic [WORD_W-1:0] rsp_read_word_ff;
   logic rsp_status_ff, rsp_last_flag_ff;

   logic [PEND_W-1:0] pend_rd, p_wdata;
   logic [COMM_W-1:0] comm_rd, c_wdata;
   logic p_we, c_we;
   logic [ENTRY_W-1:0] p_waddr, c_waddr, raddr;
   logic out_free;
   logic [WORD_W-1:0] rd_word;

   hrrm_ram #(.WIDTH(PEND_W), .DEPTH(REGION_DEPTH)) u_pend (
      .clock(clock), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
      .rd_addr(raddr), .rd_data(pend_rd)
   );
   hrrm_ram #(.WIDTH(COMM_W), .DEPTH(REGION_DEPTH)) u_comm (
      .clock(clock), .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
      .rd_addr(raddr), .rd_data(comm_rd)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_word = rsp_read_word_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last_flag = rsp_last_flag_ff;

   // row layout: marks, qword, dword, memory word, output word
   always_comb begin
      raddr = (state_ff == S_EXCH) ? cnt_ff[ENTRY_W-1:0] : head.entry;
      case (head.region)
         R_OUT: rd_word = comm_rd[15:0];
         R_MEM: rd_word = comm_rd[31:16];
         R_DWORD: rd_word = head.part[0] ? comm_rd[47:32] : comm_rd[63:48];
         default: rd_word = comm_rd[64 + 16 * (3 - head.part) +: 16];
      endcase
   end

   always_comb begin
      p_we = 1'b0;
      p_waddr = head.entry;
      p_wdata = pend_rd;
      c_we = 1'b0;
      c_waddr = waddr_ff;
      c_wdata = comm_rd;
      pop = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            p_we = 1'b1;
            c_we = 1'b1;
            p_waddr = cnt_ff[ENTRY_W-1:0];
            c_waddr = cnt_ff[ENTRY_W-1:0];
            p_wdata = '0;
            c_wdata = '0;
         end
         S_DO: begin
            if (out_free) begin
               pop = 1'b1;
               if (head.kind == K_WRITE) begin
                  p_we = 1'b1;
                  case (head.region)
                     R_OUT: begin
                        p_wdata[15:0] = head.word;
                        p_wdata[COMM_W + MARK_OUT] = 1'b1;
                     end
                     R_MEM: begin
                        p_wdata[31:16] = head.word;
                        p_wdata[COMM_W + MARK_MEM] = 1'b1;
                     end
                     R_DWORD: begin
                        if (head.part[0]) begin
                           p_wdata[47:32] = head.word;
                        end else begin
                           p_wdata[63:48] = head.word;
                        end
                        p_wdata[COMM_W + MARK_DWORD] = 1'b1;
                     end
                     default: begin
                        p_wdata[64 + 16 * (3 - head.part) +: 16] = head.word;
                        p_wdata[COMM_W + MARK_QWORD] = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_EXCH: begin
            if (wvld_ff) begin
               p_we = 1'b1;
               p_waddr = waddr_ff;
               p_wdata = {4'b0000, pend_rd[COMM_W-1:0]};
               c_we = 1'b1;
               if (pend_rd[COMM_W + MARK_OUT]) c_wdata[15:0] = pend_rd[15:0];
               if (pend_rd[COMM_W + MARK_MEM]) c_wdata[31:16] = pend_rd[31:16];
               if (pend_rd[COMM_W + MARK_DWORD]) c_wdata[63:32] = pend_rd[63:32];
               if (pend_rd[COMM_W + MARK_QWORD]) c_wdata[127:64] = pend_rd[127:64];
            end
         end
         S_EXDONE: pop = out_free;
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         wvld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_CNT) begin
                  cnt_ff <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (head_valid) begin
                  cnt_ff <= '0;
                  state_ff <= (head.kind == K_EXCH) ? S_EXCH : S_DO;
               end
            end
            S_DO: begin
               if (out_free) state_ff <= S_IDLE;
            end
            S_EXCH: begin
               wvld_ff <= (cnt_ff != DEPTH_CNT);
               waddr_ff <= cnt_ff[ENTRY_W-1:0];
               if (cnt_ff != DEPTH_CNT) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end else if (!wvld_ff) begin
                  state_ff <= S_EXDONE;
               end
            end
            S_EXDONE: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (pop) begin
         rsp_read_word_ff <= (head.kind == K_READ) ? rd_word : '0;
         rsp_status_ff <= head.err;
         rsp_last_flag_ff <= head.last;
      end
   end

   assert property (@(posedge clock) disable iff (reset) wvld_ff |-> state_ff == S_EXCH)
      else $error("commit write outside exchange");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_read_word_ff == '0)
      else $error("error item with data");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == S_DO || state_ff == S_EXDONE)
      else $error("item retired outside completion");
endmodule
`default_nettype wire

FILE: design/holding_register_region_map.sv
// path of a word item: the queue, then the idle state, then the access state, which registers its result
// word items are carried out one at a time (registered read then write of one memory row)
// exchange walks every entry, committing marked fields, before it leaves the queue with its result
// reset: synchronous; a clearing pass over every entry zeroes both memories,
// during which items queue (up to two) but are not carried out
`default_nettype none
module holding_register_region_map import hrrm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_operation,
   input wire logic [IDX_W-1:0] req_reg_index,
   input wire logic [WORD_W-1:0] req_write_word,
   input wire logic req_last_word,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [WORD_W-1:0] rsp_read_word,
   output logic rsp_status,
   output logic rsp_last_flag
);
   item_type new_item, head;
   logic full, head_valid, pop;

   assign req_ready = !full;

   hrrm_front u_front (
      .req_operation(req_operation), .req_reg_index(req_reg_index),
      .req_write_word(req_write_word), .req_last_word(req_last_word), .item(new_item)
   );

   hrrm_queue u_queue (
      .clock(clock), .reset(reset), .push(req_valid && !full), .push_item(new_item),
      .full(full), .pop(pop), .head_valid(head_valid), .head(head)
   );

   hrrm_back u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_word(rsp_read_word),
      .rsp_status(rsp_status), .rsp_last_flag(rsp_last_flag)
   );
endmodule
`default_nettype wire

FILE: tb/sv/tb_holding_register_region_map.sv
`default_nettype none
module tb_holding_register_region_map;
   import hrrm_pkg::*;

   localparam int D = REGION_DEPTH;
   localparam int WATCHDOG_LIMIT = 40 * D + 20000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_operation;
   logic [IDX_W-1:0] req_reg_index;
   logic [WORD_W-1:0] req_write_word;
   logic req_last_word;
   logic rsp_valid;
   logic rsp_ready;
   logic [WORD_W-1:0] rsp_read_word;
   logic rsp_status;
   logic rsp_last_flag;

   holding_register_region_map dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_reg_index(req_reg_index),
      .req_write_word(req_write_word),
      .req_last_word(req_last_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_word(rsp_read_word),
      .rsp_status(rsp_status),
      .rsp_last_flag(rsp_last_flag)
   );

   typedef struct packed {
      logic [WORD_W-1:0] read_word;
      logic status;
      logic last_flag;
   } answer_type;

   typedef struct {
      logic [1:0] op;
      logic [15:0] idx;
      logic [15:0] word;
      logic last;
      logic known;
      answer_type answer;
   } stim_row_type;

   logic [15:0] out_live [D];
   logic [15:0] mem_live [D];
   logic [31:0] dword_live [D];
   logic [63:0] qword_live [D];
   logic [15:0] out_staged [D];
   logic [15:0] mem_staged [D];
   logic [31:0] dword_staged [D];
   logic [63:0] qword_staged [D];
   logic [3:0] staged_marks [D];

   answer_type answers_due [$];
   int mismatches = 0;
   int items_sent = 0;
   int answers_seen = 0;
   int reads_sent = 0;
   int writes_sent = 0;
   int exchanges_sent = 0;
   int errors_sent = 0;
   int idle_cycles = 0;
   bit stimulus_done = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("answer %0d: %s got %h want %h", answers_seen, what, got, want);
      mismatches++;
   endtask

   function automatic answer_type predict_access(input logic [1:0] op, input logic [15:0] idx,
                                                 input logic [15:0] word, input logic last);
      answer_type a;
      int e;
      int off;
      int sh;
      a = '0;
      a.last_flag = last;
      if (op == OP_EXCHANGE) begin
         for (int i = 0; i < D; i++) begin
            if (staged_marks[i][MARK_OUT]) out_live[i] = out_staged[i];
            if (staged_marks[i][MARK_MEM]) mem_live[i] = mem_staged[i];
            if (staged_marks[i][MARK_DWORD]) dword_live[i] = dword_staged[i];
            if (staged_marks[i][MARK_QWORD]) qword_live[i] = qword_staged[i];
            staged_marks[i] = '0;
         end
      end else if (op == OP_READ || op == OP_WRITE) begin
         if (idx >= 8 * D) begin
            a.status = 1'b1;
         end else if (idx < D) begin
            e = idx;
            if (op == OP_WRITE) begin
               out_staged[e] = word;
               staged_marks[e][MARK_OUT] = 1'b1;
            end else a.read_word = out_live[e];
         end else if (idx < 2 * D) begin
            e = idx - D;
            if (op == OP_WRITE) begin
               mem_staged[e] = word;
               staged_marks[e][MARK_MEM] = 1'b1;
            end else a.read_word = mem_live[e];
         end else if (idx < 4 * D) begin
            off = idx - 2 * D;
            e = off >> 1;
            sh = (off & 1) ? 0 : 16;
            if (op == OP_WRITE) begin
               dword_staged[e][sh +: 16] = word;
               staged_marks[e][MARK_DWORD] = 1'b1;
            end else a.read_word = dword_live[e][sh +: 16];
         end else begin
            off = idx - 4 * D;
            e = off >> 2;
            sh = (3 - (off & 3)) * 16;
            if (op == OP_WRITE) begin
               qword_staged[e][sh +: 16] = word;
               staged_marks[e][MARK_QWORD] = 1'b1;
            end else a.read_word = qword_live[e][sh +: 16];
         end
      end
      return a;
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [15:0] idx,
                            input logic [15:0] word, input logic last,
                            input logic known, input answer_type typed);
      answer_type a;
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
            @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_reg_index <= idx;
      req_write_word <= word;
      req_last_word <= last;
      do @(posedge clock); while (!req_ready);
      a = predict_access(op, idx, word, last);
      if (known && a != typed)
         $display("directed row %0d: table entry disagrees with prediction", items_sent);
      answers_due.push_back(known ? typed : a);
      items_sent++;
      case (op)
         OP_READ: reads_sent++;
         OP_WRITE: writes_sent++;
         OP_EXCHANGE: exchanges_sent++;
         default: ;
      endcase
      if ((op == OP_READ || op == OP_WRITE) && idx >= 8 * D) errors_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            $display("answer %0d: unexpected item", answers_seen);
            mismatches++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_read_word !== want.read_word)
               report_mismatch("read_word", rsp_read_word, want.read_word);
            if (rsp_status !== want.status)
               report_mismatch("status", {15'd0, rsp_status}, {15'd0, want.status});
            if (rsp_last_flag !== want.last_flag)
               report_mismatch("last_flag", {15'd0, rsp_last_flag}, {15'd0, want.last_flag});
         end
         answers_seen++;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 3) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(10, 50)) @(negedge clock);
      end else if (stimulus_done) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("holding_register_region_map: mismatch");
         $finish;
      end
   end

   function automatic logic [15:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 16'(8 * D + $urandom_range(0, 65535 - 8 * D));
      if (r < 20) return 16'($urandom_range(0, 2 * D - 1));
      if (r < 35) return 16'(2 * D + $urandom_range(0, 2 * D - 1));
      if (r < 50) begin
         case ($urandom_range(0, 3))
            0: return 16'(0);
            1: return 16'(2 * D - 1);
            2: return 16'(8 * D - 1);
            default: return 16'(4 * D);
         endcase
      end
      return 16'(4 * D + $urandom_range(0, 4 * D - 1));
   endfunction

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      logic [15:0] base;
      int quarters;
      for (int i = 0; i < D; i++) begin
         out_live[i] = '0;  mem_live[i] = '0;  dword_live[i] = '0;  qword_live[i] = '0;
         out_staged[i] = '0;  mem_staged[i] = '0;  dword_staged[i] = '0;
         qword_staged[i] = '0;  staged_marks[i] = '0;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_READ;
      req_reg_index = '0;
      req_write_word = '0;
      req_last_word = 1'b0;
      rsp_ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      rows = '{
         '{OP_READ, 16'd0, 16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
         '{OP_READ, 16'd8191, 16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b0}},
         '{OP_READ, 16'd8192, 16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b1}},
         '{OP_WRITE, 16'hffff, 16'hffff, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0}},
         '{OP_WRITE, 16'd0, 16'hffff, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b0}},
         '{OP_WRITE, 16'd1023, 16'h8001, 1'b0, 1'b0, '0},
         '{OP_WRITE, 16'd1024, 16'h1234, 1'b0, 1'b0, '0},
         '{OP_WRITE, 16'd2047, 16'h5678, 1'b0, 1'b0, '0},
         '{OP_WRITE, 16'd2048, 16'habcd, 1'b0, 1'b0, '0},
         '{OP_WRITE, 16'd4095, 16'h0f0f, 1'b0, 1'b0, '0},
         '{OP_WRITE, 16'd4096, 16'h1111, 1'b0, 1'b0, '0},
         '{OP_WRITE, 16'd4097, 16'h2222, 1'b0, 1'b0, '0},
         '{OP_WRITE, 16'd8191, 16'h4444, 1'b1, 1'b0, '0},
         '{OP_READ, 16'd0, 16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b0, 1'b0}},
         '{OP_UNUSED, 16'hffff, 16'hffff, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
         '{OP_EXCHANGE, 16'h1234, 16'hffff, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
         '{OP_READ, 16'd0, 16'h0000, 1'b0, 1'b1, '{16'hffff, 1'b0, 1'b0}},
         '{OP_READ, 16'd2048, 16'h0000, 1'b0, 1'b0, '0},
         '{OP_READ, 16'd2049, 16'h0000, 1'b0, 1'b0, '0},
         '{OP_READ, 16'd4096, 16'h0000, 1'b0, 1'b0, '0},
         '{OP_READ, 16'd4098, 16'h0000, 1'b0, 1'b0, '0},
         '{OP_READ, 16'd8191, 16'h0000, 1'b0, 1'b0, '0},
         '{OP_WRITE, 16'd2049, 16'h7777, 1'b0, 1'b0, '0},
         '{OP_EXCHANGE, 16'd0, 16'h0000, 1'b1, 1'b0, '0},
         '{OP_READ, 16'd2048, 16'h0000, 1'b1, 1'b0, '0}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_item(row.op, row.idx, row.word, row.last, row.known, row.answer);
      end

      // write bursts (whole dwords and qwords), sometimes an exchange, then read back; random items between
      while (items_sent < 775) begin
         if ($urandom_range(0, 9) < 7) begin
            base = pick_index();
            quarters = (base >= 4 * D && base < 8 * D) ? 4 :
                       (base >= 2 * D && base < 4 * D) ? 2 : $urandom_range(1, 3);
            if (quarters == 4) base = base & ~16'd3;
            if (quarters == 2) base = base & ~16'd1;
            for (int q = 0; q < quarters; q++)
               send_item(OP_WRITE, 16'(base + q), 16'($urandom), q == quarters - 1, 0, '0);
            if ($urandom_range(0, 2) == 0)
               send_item(OP_EXCHANGE, 16'($urandom), 16'($urandom), 1'b1, 0, '0);
            for (int q = 0; q < quarters; q++)
               send_item(OP_READ, 16'(base + q), 16'($urandom), q == quarters - 1, 0, '0);
         end else begin
            send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                      1'($urandom), 0, '0);
         end
         if (items_sent > 400 && items_sent < 420) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (answers_due.size() != 0);
         end
      end

      req_valid <= 1'b0;
      stimulus_done = 1;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (2 * D + 20) @(negedge clock);
      $display("%0d items: %0d reads, %0d writes, %0d exchanges, %0d out of range",
               items_sent, reads_sent, writes_sent, exchanges_sent, errors_sent);
      $display("%0d answers checked, %0d mismatches", answers_seen, mismatches);
      if (mismatches == 0 && answers_due.size() == 0)
         $display("holding_register_region_map: match");
      else
         $display("holding_register_region_map: mismatch");
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
design/hrrm_pkg.sv
design/hrrm_ram.sv
design/hrrm_front.sv
design/hrrm_queue.sv
design/hrrm_back.sv
design/holding_register_region_map.sv
tb/sv/tb_holding_register_region_map.sv
